>>> hdl/versioned_key_slot_table_core_macros.svh
// Assertion macros for the versioned key slot table core
`ifndef VERSIONED_KEY_SLOT_TABLE_CORE_MACROS_SVH
`define VERSIONED_KEY_SLOT_TABLE_CORE_MACROS_SVH

// check a condition in the same cycle as its trigger
`define VKST_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define VKST_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> hdl/vkst_pkg.sv
// Shared constants, codes and control types of the versioned key slot table
`timescale 1ns / 1ps

package vkst_pkg;

  localparam int NUM_KEYS    = 1024;
  localparam int VALUE_W     = 64;
  localparam int IDX_W       = $clog2(NUM_KEYS);
  localparam int CNT_W       = IDX_W + 1;

  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int KEY_INDEX_W = 10;
  localparam int VERSION_W   = 32;
  localparam int VALUE_IO_W  = 64;

  localparam int IN_FIELDS_W  = KEY_INDEX_W + VERSION_W + VALUE_IO_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + KEY_INDEX_W + VERSION_W + VALUE_IO_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_KEYS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_key;
    logic clearing;
    logic exec;
  } vkst_cmd_t;

  typedef struct packed {
    logic create_pop;
    logic clear_last;
    logic out_stall;
  } vkst_stat_t;

endpackage

>>> hdl/versioned_key_slot_table_core.sv
// An accepted item is registered, a create that reuses an index then reads it from the free
// stack in the load state, the read state reads the tables, and the exec state writes the
// result to the output register. The next item is accepted while a result still waits there;
// its exec state holds while that result stalls the output.
// Reset: synchronous; counters clear at once, then a pass over all 1024 entries zeroes both
// version tables, with s_tready low until it completes.
`timescale 1ns / 1ps

module versioned_key_slot_table_core
  import vkst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // key_index, key_version, value_in
  input  logic [CMD_W-1:0]      s_tuser,  // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // status, new_index, new_version, value_out, value_found
);

  vkst_cmd_t  cmd;
  vkst_stat_t stat;

  vkst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vkst_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> hdl/vkst_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module vkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/vkst_ctrl.sv
// Controller state machine of the versioned key slot table
`timescale 1ns / 1ps

module vkst_ctrl
  import vkst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  vkst_stat_t stat,
  output vkst_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready     = (state == S_IDLE);
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.load_key = (state == S_LOAD);
  assign cmd.clearing = (state == S_CLEAR);
  assign cmd.exec     = (state == S_EXEC) && !stat.out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = stat.create_pop ? S_LOAD : S_READ;
        end
      end
      S_LOAD: state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (!stat.out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/vkst_dp.sv
// Datapath of the versioned key slot table: tables, free stack, counters, result register
`timescale 1ns / 1ps

module vkst_dp
  import vkst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  vkst_cmd_t             cmd,
  output vkst_stat_t            stat
);

  logic [KEY_INDEX_W-1:0] in_index;
  logic [VERSION_W-1:0]   in_version;
  logic [VALUE_IO_W-1:0]  in_value;

  logic [CMD_W-1:0]     op;
  logic [IDX_W-1:0]     key_idx;
  logic [VERSION_W-1:0] op_version;
  logic [VALUE_W-1:0]   op_value;
  logic                 op_in_range;

  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] free_count_next;
  logic [CNT_W-1:0] used_count;
  logic [CNT_W-1:0] used_count_next;
  logic [CNT_W-1:0] stack_top;
  logic [IDX_W-1:0] clr_cnt;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [KEY_INDEX_W-1:0] out_nidx;
  logic [VERSION_W-1:0]  out_nver;
  logic [VALUE_IO_W-1:0] out_vout;
  logic                  out_found;

  logic [STATUS_W-1:0]   res_status;
  logic [KEY_INDEX_W-1:0] res_nidx;
  logic [VERSION_W-1:0]  res_nver;
  logic [VALUE_IO_W-1:0] res_vout;
  logic                  res_found;

  logic                 cur_we_op;
  logic [VERSION_W-1:0] cur_wdata_op;
  logic                 stack_we_op;
  logic                 slot_we_op;
  logic [VERSION_W-1:0] bumped;

  logic                 cur_we;
  logic [IDX_W-1:0]     ver_waddr;
  logic [VERSION_W-1:0] cur_wdata;
  logic                 slotv_we;
  logic [VERSION_W-1:0] slotv_wdata;

  logic [VERSION_W-1:0] cur_rdata;
  logic [VERSION_W-1:0] slotv_rdata;
  logic [VALUE_W-1:0]   slotval_rdata;
  logic [IDX_W-1:0]     stack_rdata;
  logic [IDX_W-1:0]     stack_raddr;

  assign in_index   = s_tdata[KEY_INDEX_W-1:0];
  assign in_version = s_tdata[KEY_INDEX_W +: VERSION_W];
  assign in_value   = s_tdata[KEY_INDEX_W+VERSION_W +: VALUE_IO_W];

  assign stack_top   = free_count - CNT_W'(1);
  assign stack_raddr = stack_top[IDX_W-1:0];

  assign stat.create_pop = (s_tuser == CMD_CREATE) && (free_count != '0);
  assign stat.clear_last = &clr_cnt;
  assign stat.out_stall  = out_valid && !m_tready;

  assign bumped = (cur_rdata == '1) ? VERSION_W'(1) : cur_rdata + VERSION_W'(1);

  always_comb begin
    res_status      = ST_OK;
    res_nidx        = '0;
    res_nver        = '0;
    res_vout        = '0;
    res_found       = 1'b0;
    cur_we_op       = 1'b0;
    cur_wdata_op    = bumped;
    stack_we_op     = 1'b0;
    slot_we_op      = 1'b0;
    free_count_next = free_count;
    used_count_next = used_count;
    unique case (op)
      CMD_CREATE: begin
        if ((free_count != '0) || (used_count < CNT_W'(NUM_KEYS))) begin
          if (free_count != '0) begin
            free_count_next = stack_top;
          end else begin
            used_count_next = used_count + CNT_W'(1);
          end
          cur_we_op    = (cur_rdata == '0);
          cur_wdata_op = VERSION_W'(1);
          res_nidx     = KEY_INDEX_W'(key_idx);
          res_nver     = (cur_rdata == '0) ? VERSION_W'(1) : cur_rdata;
        end else begin
          res_status = ST_NO_KEYS;
        end
      end
      CMD_DELETE: begin
        if (op_in_range && (op_version == cur_rdata) &&
            (free_count < CNT_W'(NUM_KEYS))) begin
          cur_we_op       = 1'b1;
          stack_we_op     = 1'b1;
          free_count_next = free_count + CNT_W'(1);
        end else begin
          res_status = ST_INVALID;
        end
      end
      CMD_SET: begin
        if (op_in_range && (op_version == cur_rdata)) begin
          slot_we_op = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
      end
      CMD_GET: begin
        if (op_in_range && (slotv_rdata == op_version)) begin
          res_vout  = VALUE_IO_W'(slotval_rdata);
          res_found = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  assign cur_we      = cmd.clearing || (cmd.exec && cur_we_op);
  assign ver_waddr   = cmd.clearing ? clr_cnt : key_idx;
  assign cur_wdata   = cmd.clearing ? '0 : cur_wdata_op;
  assign slotv_we    = cmd.clearing || (cmd.exec && slot_we_op);
  assign slotv_wdata = cmd.clearing ? '0 : op_version;

  vkst_ram #(.WIDTH(VERSION_W), .DEPTH(NUM_KEYS)) u_cur_ver (
    .clk   (clk),
    .we    (cur_we),
    .waddr (ver_waddr),
    .wdata (cur_wdata),
    .raddr (key_idx),
    .rdata (cur_rdata)
  );

  vkst_ram #(.WIDTH(VERSION_W), .DEPTH(NUM_KEYS)) u_slot_ver (
    .clk   (clk),
    .we    (slotv_we),
    .waddr (ver_waddr),
    .wdata (slotv_wdata),
    .raddr (key_idx),
    .rdata (slotv_rdata)
  );

  vkst_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_KEYS)) u_slot_val (
    .clk   (clk),
    .we    (cmd.exec && slot_we_op),
    .waddr (key_idx),
    .wdata (op_value),
    .raddr (key_idx),
    .rdata (slotval_rdata)
  );

  vkst_ram #(.WIDTH(IDX_W), .DEPTH(NUM_KEYS)) u_free_stack (
    .clk   (clk),
    .we    (cmd.exec && stack_we_op),
    .waddr (free_count[IDX_W-1:0]),
    .wdata (key_idx),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op          <= s_tuser;
      op_version  <= in_version;
      op_value    <= in_value[VALUE_W-1:0];
      op_in_range <= (32'(in_index) < NUM_KEYS);
      key_idx     <= (s_tuser == CMD_CREATE) ? used_count[IDX_W-1:0] : IDX_W'(in_index);
    end else if (cmd.load_key) begin
      key_idx <= stack_rdata;
    end
    if (cmd.exec) begin
      out_status <= res_status;
      out_nidx   <= res_nidx;
      out_nver   <= res_nver;
      out_vout   <= res_vout;
      out_found  <= res_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      used_count <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clearing) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (cmd.exec) begin
        free_count <= free_count_next;
        used_count <= used_count_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                     out_found, out_vout, out_nver, out_nidx, out_status};

endmodule

>>> hdl/vkst_checker.sv
// Port-level assertions for the versioned key slot table core, with bind
`timescale 1ns / 1ps
`include "versioned_key_slot_table_core_macros.svh"

module vkst_checker
  import vkst_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  `VKST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `VKST_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second item taken while one is in flight")
  `VKST_ASSERT_SAME(a_status_code, m_tvalid, m_tdata[STATUS_W-1:0] != 2'd3, "undefined status code")
  `VKST_ASSERT_SAME(a_found_ok, m_tvalid && m_tdata[OUT_FIELDS_W-1], m_tdata[STATUS_W-1:0] == ST_OK, "value found without ok status")
  `VKST_ASSERT_SAME(a_no_keys_empty, m_tvalid && (m_tdata[STATUS_W-1:0] == ST_NO_KEYS), m_tdata[OUT_FIELDS_W-1:STATUS_W] == '0, "no keys result carries data")

endmodule

bind versioned_key_slot_table_core vkst_checker u_vkst_checker (.*);

>>> verif/versioned_key_slot_table_core_tb.sv
// Self-checking testbench for the versioned key slot table core
`timescale 1ns / 1ps

module versioned_key_slot_table_core_tb;
  import vkst_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PRINT_LIMIT     = 40;

  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
    logic                               value_found;
    logic [VALUE_IO_W-1:0]              value_out;
    logic [VERSION_W-1:0]               new_version;
    logic [KEY_INDEX_W-1:0]             new_index;
    logic [STATUS_W-1:0]                status;
  } key_reply_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = CMD_CREATE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [VERSION_W-1:0]   key_version_tbl  [NUM_KEYS];
  logic [KEY_INDEX_W-1:0] free_stack_tbl   [NUM_KEYS];
  logic [VERSION_W-1:0]   slot_version_tbl [NUM_KEYS];
  logic [VALUE_IO_W-1:0]  slot_value_tbl   [NUM_KEYS];
  bit                     slot_written     [NUM_KEYS];
  int                     free_depth  = 0;
  int                     keys_issued = 0;

  key_reply_t pending_replies[$];
  int         err_count    = 0;
  bit         tx_gaps_on   = 1'b1;
  bit         rx_stalls_on = 1'b1;
  logic       hold_rx      = 1'b0;
  event       hold_go;

  versioned_key_slot_table_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic key_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [KEY_INDEX_W-1:0] idx,
                                               input logic [VERSION_W-1:0] ver,
                                               input logic [VALUE_IO_W-1:0] val);
    key_reply_t             r;
    logic [KEY_INDEX_W-1:0] k;
    logic [VERSION_W-1:0]   bumped;
    r = '0;
    case (cmd)
      CMD_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          k = free_stack_tbl[free_depth];
        end else if (keys_issued < NUM_KEYS) begin
          k = KEY_INDEX_W'(keys_issued);
          keys_issued++;
        end else begin
          r.status = ST_NO_KEYS;
          return r;
        end
        if (key_version_tbl[k] == '0) key_version_tbl[k] = 1;
        r.new_index   = k;
        r.new_version = key_version_tbl[k];
      end
      CMD_DELETE: begin
        if (ver == key_version_tbl[idx] && free_depth < NUM_KEYS) begin
          bumped = key_version_tbl[idx] + 1'b1;
          if (bumped == '0) bumped = 1;
          key_version_tbl[idx] = bumped;
          free_stack_tbl[free_depth] = idx;
          free_depth++;
        end else begin
          r.status = ST_INVALID;
        end
      end
      CMD_SET: begin
        if (ver == key_version_tbl[idx]) begin
          slot_version_tbl[idx] = ver;
          slot_value_tbl[idx]   = val;
          slot_written[idx]     = 1'b1;
        end else begin
          r.status = ST_INVALID;
        end
      end
      default: begin
        if (ver == slot_version_tbl[idx]) begin
          r.value_out   = slot_value_tbl[idx];
          r.value_found = 1'b1;
        end else begin
          r.status = ST_INVALID;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < PRINT_LIMIT) begin
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_INDEX_W-1:0] idx,
                           input logic [VERSION_W-1:0] ver, input logic [VALUE_IO_W-1:0] val);
    int                   gap;
    logic [VERSION_W-1:0] v;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    v = ver;
    // keep clear of slots whose value was never stored
    if (cmd == CMD_GET && !slot_written[idx] && v == slot_version_tbl[idx]) v = ~v;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, val, v, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_replies.push_back(apply_command(cmd, idx, v, val));
  endtask

  task automatic send_random_command();
    logic [CMD_W-1:0]       cmd;
    logic [KEY_INDEX_W-1:0] idx;
    logic [VERSION_W-1:0]   ver;
    int                     pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) cmd = CMD_CREATE;
    else if (pick < 40) cmd = CMD_DELETE;
    else if (pick < 68) cmd = CMD_SET;
    else cmd = CMD_GET;
    if (keys_issued > 0 && $urandom_range(0, 9) != 0) begin
      idx = KEY_INDEX_W'($urandom_range(0, keys_issued - 1));
    end else begin
      idx = KEY_INDEX_W'($urandom_range(0, NUM_KEYS - 1));
    end
    pick = $urandom_range(0, 9);
    if (cmd == CMD_GET && pick < 7) ver = slot_version_tbl[idx];
    else if (pick < 8) ver = key_version_tbl[idx];
    else if (pick == 8) ver = key_version_tbl[idx] - 1'b1;
    else ver = $urandom;
    send_item(cmd, idx, ver, {$urandom, $urandom});
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_handles();
    send_item(CMD_CREATE, '0, '0, '0);
    send_item(CMD_CREATE, '1, '1, '1);
    send_item(CMD_GET, 10'd0, 32'd1, '0);
    send_item(CMD_SET, 10'd0, 32'd1, '1);
    send_item(CMD_GET, 10'd0, 32'd1, '0);
    send_item(CMD_SET, 10'd1, 32'd1, '0);
    send_item(CMD_GET, 10'd1, 32'd1, '1);
    send_item(CMD_SET, 10'd0, 32'd2, 64'h0123_4567_89ab_cdef);
    send_item(CMD_GET, 10'd0, 32'd0, '0);
    send_item(CMD_DELETE, 10'd0, 32'd2, '0);
    send_item(CMD_DELETE, 10'd0, 32'd1, '0);
    // stale handle still reads the old slot
    send_item(CMD_GET, 10'd0, 32'd1, '0);
    send_item(CMD_SET, 10'd0, 32'd1, '1);
    send_item(CMD_CREATE, '0, '0, '0);
    send_item(CMD_SET, 10'd0, 32'd2, 64'ha5a5_5a5a_f00f_0ff0);
    send_item(CMD_GET, 10'd0, 32'd2, '0);
    // delete of a never-created index with its current version
    send_item(CMD_DELETE, '1, '0, '0);
    send_item(CMD_CREATE, '0, '0, '0);
    send_item(CMD_SET, '1, '1, '1);
    send_item(CMD_GET, '1, '1, '0);
    send_item(CMD_SET, 10'd1022, '0, 64'hfedc_ba98_7654_3210);
    send_item(CMD_GET, 10'd1022, '0, '0);
    // free stack hands back the last freed index first
    send_item(CMD_DELETE, 10'd1, 32'd1, '0);
    send_item(CMD_DELETE, 10'd0, 32'd2, '0);
    send_item(CMD_CREATE, '0, '0, '0);
    send_item(CMD_CREATE, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 10; chunk++) begin
      tx_gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      repeat (78) send_random_command();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    -> hold_go;
    repeat (40) send_random_command();
    tx_gaps_on = 1'b1;
  endtask

  initial begin : result_sink
    int         stall_left;
    key_reply_t got;
    key_reply_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.status), 64'd0);
        end else begin
          want = pending_replies.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.new_index != want.new_index)
            report_mismatch("new_index", 64'(got.new_index), 64'(want.new_index));
          if (got.new_version != want.new_version)
            report_mismatch("new_version", 64'(got.new_version), 64'(want.new_version));
          if (got.value_out != want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
          if (got.value_found != want.value_found)
            report_mismatch("value_found", 64'(got.value_found), 64'(want.value_found));
        end
        stall_left = rx_stalls_on ? $urandom_range(0, 7) : 0;
      end
      if (hold_rx || stall_left > 0) begin
        m_tready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : rx_hold_off
    forever begin
      @(hold_go);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_rx <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", WATCHDOG_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    foreach (key_version_tbl[i]) begin
      key_version_tbl[i]  = '0;
      free_stack_tbl[i]   = '0;
      slot_version_tbl[i] = '0;
      slot_value_tbl[i]   = '0;
      slot_written[i]     = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_handles();
    drain_results();
    test_random_traffic();
    drain_results();
    test_backpressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      report_mismatch("results outstanding", 64'(pending_replies.size()), 64'd0);
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/vkst_pkg.sv
hdl/vkst_ram.sv
hdl/vkst_ctrl.sv
hdl/vkst_dp.sv
hdl/versioned_key_slot_table_core.sv
hdl/vkst_checker.sv
verif/versioned_key_slot_table_core_tb.sv
